// ----- rtl/stlfp_pkg.sv -----
// Shared types and constants for the sync/type/length frame parser.
// Used by sync_type_length_frame_parser; depends on nothing else.
package stlfp_pkg;

  localparam int PAYLOAD_DEPTH = 256;
  localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [7:0] SYNC_RESET = 8'hAA;

  typedef enum logic [2:0] {
    PH_SYNC = 3'd0,
    PH_TYPE = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_CHK  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_GOOD = 2'd1,
    ST_BAD  = 2'd2,
    ST_READ = 2'd3
  } status_t;

  typedef enum logic {
    OP_FEED = 1'b0,
    OP_READ = 1'b1
  } op_t;

endpackage

// ----- rtl/sync_type_length_frame_parser.sv -----
// Sync/type/length/payload/XOR-checksum frame parser with payload read-back.
// Depends on stlfp_pkg (phase, status and op codes, payload depth).
//
// Takes one word per cycle, back to back, while in_ready is high. Every word
// gives exactly one result word. The payload store is a synchronous RAM with
// a registered read, so a read word passes one stage that waits for the RAM
// data, then lands in the output register. The parse state is updated and
// the payload byte written in the cycle a word is accepted, so each word sees
// all earlier words. While a result waits in the output register, one more
// word is taken into the middle stage.
// No clearing pass is needed after reset; reading a payload entry never
// written gives an undefined byte.
module sync_type_length_frame_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_read_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_frame_type,
  output logic [7:0] out_frame_length,
  output logic [7:0] out_read_data
);

  localparam int AW = stlfp_pkg::ADDR_W;

  // Configuration and parse state
  logic [7:0] sync_r;
  stlfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] type_r, type_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] check_r, check_nxt;
  stlfp_pkg::status_t status_nxt;

  // Payload RAM
  logic [7:0]    mem [stlfp_pkg::PAYLOAD_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic          mem_re;
  logic [7:0]    mem_q_r;

  // Middle stage and output register
  logic               s1_valid_r;
  stlfp_pkg::status_t s1_status_r;
  logic [7:0]         s1_type_r;
  logic [7:0]         s1_length_r;
  logic               s1_rd_r;
  logic               s1_adv;
  logic               accept;
  logic               in_range;

  stlfp_pkg::status_t out_status_r;
  logic [7:0]         out_type_r;
  logic [7:0]         out_length_r;
  logic [7:0]         out_data_r;
  logic               out_valid_r;

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  assign in_range  = {1'b0, in_read_index} < 9'(stlfp_pkg::PAYLOAD_DEPTH);
  assign mem_raddr = in_read_index[AW-1:0];
  assign mem_re    = accept && (in_op == stlfp_pkg::OP_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= stlfp_pkg::SYNC_RESET;
    end else if (cfg_we) begin
      sync_r <= cfg_wdata;
    end
  end

  // Next parse state for a fed byte; reads leave the parse untouched
  always_comb begin
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    check_nxt  = check_r;
    status_nxt = stlfp_pkg::ST_BUSY;
    mem_we     = 1'b0;
    mem_waddr  = count_r[AW-1:0];
    if (in_op == stlfp_pkg::OP_READ) begin
      status_nxt = stlfp_pkg::ST_READ;
    end else begin
      case (phase_r)
        stlfp_pkg::PH_TYPE: begin
          type_nxt  = in_rx_byte;
          check_nxt = in_rx_byte;
          phase_nxt = stlfp_pkg::PH_LEN;
        end
        stlfp_pkg::PH_LEN: begin
          length_nxt = in_rx_byte;
          check_nxt  = check_r ^ in_rx_byte;
          count_nxt  = 8'd0;
          phase_nxt  = (in_rx_byte == 8'd0) ? stlfp_pkg::PH_CHK : stlfp_pkg::PH_DATA;
        end
        stlfp_pkg::PH_DATA: begin
          // bytes past the store depth still count toward the checksum
          mem_we    = {1'b0, count_r} < 9'(stlfp_pkg::PAYLOAD_DEPTH);
          check_nxt = check_r ^ in_rx_byte;
          count_nxt = count_r + 8'd1;
          if (count_nxt >= length_r) begin
            phase_nxt = stlfp_pkg::PH_CHK;
          end
        end
        stlfp_pkg::PH_CHK: begin
          phase_nxt  = stlfp_pkg::PH_SYNC;
          status_nxt = (in_rx_byte == check_r) ? stlfp_pkg::ST_GOOD : stlfp_pkg::ST_BAD;
        end
        default: begin
          phase_nxt = (in_rx_byte == sync_r) ? stlfp_pkg::PH_TYPE : stlfp_pkg::PH_SYNC;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= stlfp_pkg::PH_SYNC;
      type_r   <= 8'd0;
      length_r <= 8'd0;
      count_r  <= 8'd0;
      check_r  <= 8'd0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      check_r  <= check_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      mem[mem_waddr] <= in_rx_byte;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  // Middle stage: hold the result fields while the RAM read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status_nxt;
      s1_type_r   <= type_nxt;
      s1_length_r <= length_nxt;
      s1_rd_r     <= (in_op == stlfp_pkg::OP_READ) && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_status_r <= s1_status_r;
      out_type_r   <= s1_type_r;
      out_length_r <= s1_length_r;
      out_data_r   <= s1_rd_r ? mem_q_r : 8'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_frame_type   = out_type_r;
  assign out_frame_length = out_length_r;
  assign out_read_data    = out_data_r;

  a_data_len_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == stlfp_pkg::PH_DATA |-> length_r != 8'd0)
    else $error("payload phase with zero length");

  a_count_below_len : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == stlfp_pkg::PH_DATA |-> count_r < length_r)
    else $error("payload count reached length inside payload phase");

  a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted word missing from middle stage");

  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_status_r) && $stable(mem_q_r))
    else $error("stalled middle stage lost its word");

  a_no_accept_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken with both stages full");

endmodule
